/* rtl/core/etp_pkg.sv */
// shared constants, types and codes for the empirical tail p-value block
// used by every module under rtl/core but etp_ram, and by the checker
package etp_pkg;

    localparam int NULL_DEPTH  = 4096;
    localparam int P_FRAC_BITS = 16;

    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = $clog2(NULL_DEPTH);
    localparam int COUNT_W  = $clog2(NULL_DEPTH + 1);
    localparam int P_W      = P_FRAC_BITS + 1;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

/* rtl/core/etp_ram.sv */
// generic single-port synchronous ram with registered read
// no dependencies
module etp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/etp_div.sv */
// restoring divider: floor(tail * 2^P_FRAC_BITS / count), one quotient bit a cycle
// depends on etp_pkg; expects tail <= count and count nonzero
module etp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [etp_pkg::COUNT_W-1:0]  dividend,
    input  logic [etp_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic [etp_pkg::P_W-1:0]      quotient
);

    import etp_pkg::*;

    localparam int STEP_W = $clog2(P_FRAC_BITS + 1);

    logic                 busy_reg,    busy_next;
    logic                 done_reg,    done_next;
    logic [STEP_W-1:0]    step_reg,    step_next;
    logic [COUNT_W:0]     rem_reg,     rem_next;
    logic [COUNT_W-1:0]   dvs_reg,     dvs_next;
    logic [P_W-1:0]       quo_reg,     quo_next;
    logic [COUNT_W:0]     shifted;
    logic                 ge;

    // first step compares the plain remainder, later steps bring in a zero bit
    always_comb
    begin
        shifted = (step_reg == '0) ? rem_reg : {rem_reg[COUNT_W-1:0], 1'b0};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, dividend};
            dvs_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[P_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(P_FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/empirical_tail_pvalue.sv */
// empirical upper-tail p-value against a stored table of null values
// depends on etp_pkg, etp_ram and etp_div
//
// One item is worked at a time, and every item gives one result word. A clear,
// a load, an unused command or a query on an empty table goes from acceptance
// to the S_OUT state and from there into the output register. A query reads the
// null table through the single ram port, one entry a cycle, then runs a 17-step
// restoring divide before its result goes through S_OUT into the output register.
// A result word that is still held by out_stall delays the next one by the stall.
// The output register lets a new word be accepted while the previous result is
// still waiting to be taken. The table is not cleared after reset: only entries
// below the fill count are ever read.
module empirical_tail_pvalue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [etp_pkg::CMD_W-1:0]           command,
    input  logic signed [etp_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [etp_pkg::P_W-1:0]             p_value,
    output logic [etp_pkg::COUNT_W-1:0]         tail_count,
    output logic [etp_pkg::STATUS_W-1:0]        status
);

    import etp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg,   state_next;
    logic [COUNT_W-1:0]   count_reg,   count_next;
    logic [COUNT_W-1:0]   idx_reg,     idx_next;
    logic [COUNT_W-1:0]   tail_reg,    tail_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic signed [VALUE_W-1:0] query_reg, query_next;
    logic [P_W-1:0]       res_p_reg,   res_p_next;
    status_t              res_st_reg,  res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [P_W-1:0]       p_reg,       p_next;
    logic [COUNT_W-1:0]   tcnt_reg,    tcnt_next;
    status_t              st_reg,      st_next;

    logic                 accept;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [P_W-1:0]       div_quo;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // table write on an accepted load with room, otherwise scan reads
    assign ram_we   = accept && (cmd_t'(command) == CMD_LOAD)
                      && (count_reg < COUNT_W'(NULL_DEPTH));
    assign ram_addr = (state_reg == S_IDLE) ? count_reg[ADDR_W-1:0]
                                            : idx_reg[ADDR_W-1:0];

    etp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NULL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value),
        .rdata (ram_rdata)
    );

    etp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tail_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        tail_next      = tail_reg;
        rd_pend_next   = 1'b0;
        query_next     = query_reg;
        res_p_next     = res_p_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && out_stall;
        p_next         = p_reg;
        tcnt_next      = tcnt_reg;
        st_next        = st_reg;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_p_next  = '0;
                    tail_next   = '0;
                    res_st_next = ST_OK;
                    state_next  = S_OUT;
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_st_next = ST_FULL;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                query_next = value;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // count the entry that came back from last cycle's read
                if (rd_pend_reg && ($signed(ram_rdata) >= query_reg))
                begin
                    tail_next = tail_reg + 1'b1;
                end
                if (idx_reg < count_reg)
                begin
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_p_next = div_quo;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // move the result into the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    p_next         = res_p_reg;
                    tcnt_next      = tail_reg;
                    st_next        = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            tail_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            query_reg     <= '0;
            res_p_reg     <= '0;
            res_st_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
            tcnt_reg      <= '0;
            st_reg        <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            tail_reg      <= tail_next;
            rd_pend_reg   <= rd_pend_next;
            query_reg     <= query_next;
            res_p_reg     <= res_p_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
            tcnt_reg      <= tcnt_next;
            st_reg        <= st_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign p_value    = p_reg;
    assign tail_count = tcnt_reg;
    assign status     = st_reg;

endmodule

/* rtl/core/etp_checker.sv */
// port-level checks for empirical_tail_pvalue, attached by bind
// depends on etp_pkg
module etp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [etp_pkg::P_W-1:0]             p_value,
    input  logic [etp_pkg::COUNT_W-1:0]         tail_count,
    input  logic [etp_pkg::STATUS_W-1:0]        status
);

    import etp_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(p_value)
            && $stable(tail_count) && $stable(status))
        else $error("stalled result word changed");

    // error results carry no fraction and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (p_value == '0) && (tail_count == '0))
        else $error("error result with nonzero fields");

    // fraction is zero exactly when the tail count is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((tail_count == '0) == (p_value == '0)))
        else $error("p_value disagrees with tail_count");

    // one word at a time: the block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous word in progress");

endmodule

bind empirical_tail_pvalue etp_checker u_etp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .p_value    (p_value),
    .tail_count (tail_count),
    .status     (status)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// testbench for empirical_tail_pvalue: clear, load, query and unused command words
// against an in-bench model of the null table; depends on etp_pkg and the rtl/core sources
module tb_top;

    import etp_pkg::*;

    localparam logic [CMD_W-1:0]          CMD_UNUSED  = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX     = 32'sh7fff_ffff;
    localparam int                        QUIET_LIMIT = 20000;
    localparam int                        PRINT_CAP   = 100;

    // one input word and one result word
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] val;
    } cmd_word_t;

    typedef struct packed {
        logic [P_W-1:0]      p;
        logic [COUNT_W-1:0]  cnt;
        logic [STATUS_W-1:0] st;
    } tail_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [CMD_W-1:0]             command = CMD_CLEAR;
    logic signed [VALUE_W-1:0]    value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [P_W-1:0]               p_value;
    logic [COUNT_W-1:0]           tail_count;
    logic [STATUS_W-1:0]          status;

    cmd_word_t                    pending_words[$];
    cmd_word_t                    next_word;
    tail_result_t                 tail_results_due[$];
    logic signed [VALUE_W-1:0]    null_table[NULL_DEPTH];
    int                           null_fill = 0;
    int                           send_idle_pct = 15;
    int                           recv_idle_pct = 49;
    int                           mismatches = 0;
    int                           quiet_cycles = 0;

    empirical_tail_pvalue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .p_value    (p_value),
        .tail_count (tail_count),
        .status     (status)
    );

    always #4 clk = ~clk;

    // table model: apply one word, return the result word it gives
    function automatic tail_result_t compute_tail_result(input logic [CMD_W-1:0] cmd,
                                                         input logic signed [VALUE_W-1:0] val);
        tail_result_t      r;
        int                tail;
        longint unsigned   scaled;
        r = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_CLEAR:
                null_fill = 0;
            CMD_LOAD:
            begin
                if (null_fill >= NULL_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    null_table[null_fill] = val;
                    null_fill++;
                end
            end
            CMD_QUERY:
            begin
                if (null_fill == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    tail = 0;
                    for (int i = 0; i < null_fill; i++)
                        if (null_table[i] >= val)
                            tail++;
                    scaled = longint'(tail) << P_FRAC_BITS;
                    r.p = P_W'(scaled / longint'(null_fill));
                    r.cnt = COUNT_W'(tail);
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // compare one taken result word with the oldest one due
    task automatic check_result();
        tail_result_t due;
        if (tail_results_due.size() == 0)
        begin
            report_mismatch("result word with none due");
            return;
        end
        due = tail_results_due.pop_front();
        if (p_value !== due.p)
            report_mismatch($sformatf("p_value got %0d want %0d", p_value, due.p));
        if (tail_count !== due.cnt)
            report_mismatch($sformatf("tail_count got %0d want %0d", tail_count, due.cnt));
        if (status !== due.st)
            report_mismatch($sformatf("status got %0d want %0d", status, due.st));
    endtask

    // driver: present words from the pending queue, hold while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_CLEAR;
            value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tail_results_due = {tail_results_due, compute_tail_result(command, value)};
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    command <= next_word.cmd;
                    value <= next_word.val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: take result words and stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    task automatic push_word(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] val);
        cmd_word_t w;
        w.cmd = cmd;
        w.val = val;
        pending_words = {pending_words, w};
    endtask

    // mix of tight range for ties, extremes and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 16)) - 8;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1;
                    3: return VAL_MAX - 1;
                    4: return -1;
                    default: return 0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic add_directed_words();
        push_word(CMD_QUERY, 5);
        push_word(CMD_UNUSED, -1);
        push_word(CMD_LOAD, VAL_MIN);
        push_word(CMD_LOAD, VAL_MAX);
        push_word(CMD_LOAD, 0);
        push_word(CMD_LOAD, -1);
        push_word(CMD_LOAD, 0);
        push_word(CMD_QUERY, VAL_MIN);
        push_word(CMD_QUERY, VAL_MAX);
        push_word(CMD_QUERY, 0);
        push_word(CMD_QUERY, 1);
        push_word(CMD_QUERY, -1);
        push_word(CMD_UNUSED, 32'sh5555_aaaa);
        push_word(CMD_QUERY, 0);
        push_word(CMD_CLEAR, 32'shffff_ffff);
        push_word(CMD_QUERY, 0);
        push_word(CMD_LOAD, 100);
        push_word(CMD_QUERY, 101);
        push_word(CMD_QUERY, 100);
        push_word(CMD_LOAD, 32'shaaaa_5555);
        push_word(CMD_LOAD, 32'sh5555_aaaa);
        push_word(CMD_QUERY, 32'sh5555_aaaa);
        push_word(CMD_QUERY, 32'shaaaa_5555);
    endtask

    // random bursts: mostly clear, loads, then queries aimed at the loaded values
    task automatic add_random_words(input int target);
        logic signed [VALUE_W-1:0] loaded[$];
        logic signed [VALUE_W-1:0] v;
        int                        added;
        int                        kind;
        int                        n;
        added = 0;
        while (added < target)
        begin
            kind = $urandom_range(0, 9);
            loaded.delete();
            if (kind < 7)
            begin
                push_word(CMD_CLEAR, $urandom());
                added++;
            end
            if (kind == 7)
            begin
                push_word(CMD_CLEAR, $urandom());
                push_word(CMD_QUERY, pick_value());
                added += 2;
            end
            else if (kind == 8)
            begin
                push_word(CMD_UNUSED, $urandom());
                push_word(CMD_QUERY, pick_value());
                added += 2;
            end
            else
            begin
                n = (kind < 7) ? $urandom_range(1, 24) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                begin
                    v = pick_value();
                    loaded = {loaded, v};
                    push_word(CMD_LOAD, v);
                end
                n = $urandom_range(2, 6);
                for (int i = 0; i < n; i++)
                begin
                    v = loaded[$urandom_range(0, loaded.size() - 1)];
                    case ($urandom_range(0, 3))
                        0: v = v + 1;
                        1: v = v - 1;
                        2: v = pick_value();
                        default: ;
                    endcase
                    push_word(CMD_QUERY, v);
                end
                added += loaded.size() + n;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || tail_results_due.size() != 0);
    endtask

    // stimulus in three idling phases, then the final verdict
    initial
    begin
        add_directed_words();
        add_random_words(35);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();
        send_idle_pct = 49;
        recv_idle_pct = 15;
        add_random_words(35);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_words(35);
        wait_drained();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && tail_results_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/etp_pkg.sv
rtl/core/etp_ram.sv
rtl/core/etp_div.sv
rtl/core/empirical_tail_pvalue.sv
rtl/core/etp_checker.sv
tb/sv/tb_top.sv
